/* src/nqfs_pkg.sv */
// Shared types for the N-queens first-solution block: step, condition and
// operation codes, the control word and the microprogram table.
// No dependencies; used by nqfs_seq and n_queens_first_solution.
`timescale 1ns / 1ps
`default_nettype none

package nqfs_pkg;

    localparam int SIZE_W = 5;
    localparam int FIELD_W = 5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_TRY,
        S_PLACED,
        S_BACK,
        S_RESUME,
        S_EMIT,
        S_FAIL
    } t_step;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_IN_VALID,
        C_SIZE_OK,
        C_FREE,
        C_COL_LAST,
        C_ROW_LAST,
        C_ROW_FIRST,
        C_COL_OVER,
        C_OUT_BLOCKED
    } t_cond;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PLACE,
        OP_COL_INC,
        OP_ROW_NEXT,
        OP_ROW_FIRST,
        OP_POP,
        OP_EMIT,
        OP_EMIT_NONE
    } t_op;

    typedef struct packed {
        logic in_valid;
        logic size_ok;
        logic free;
        logic col_last;
        logic row_last;
        logic row_first;
        logic col_over;
        logic out_blocked;
    } t_flags;

    // Three-way branch: first condition, else second condition, else default.
    typedef struct packed {
        t_cond cond_a;
        t_op   op_a;
        t_step tgt_a;
        t_cond cond_b;
        t_op   op_b;
        t_step tgt_b;
        t_op   op_c;
        t_step tgt_c;
        logic  in_ready;
    } t_uword;

    function automatic t_uword ucode(input t_step step);
        t_uword w;
        w = '{C_NEVER, OP_NONE, S_IDLE, C_NEVER, OP_NONE, S_IDLE, OP_NONE, S_IDLE, 1'b0};
        case (step)
            S_IDLE: begin
                w = '{C_IN_VALID, OP_LOAD, S_CHECK,
                      C_NEVER, OP_NONE, S_IDLE, OP_NONE, S_IDLE, 1'b1};
            end
            S_CHECK: begin
                w = '{C_SIZE_OK, OP_NONE, S_TRY,
                      C_NEVER, OP_NONE, S_IDLE, OP_NONE, S_FAIL, 1'b0};
            end
            S_TRY: begin
                w = '{C_FREE, OP_PLACE, S_PLACED,
                      C_COL_LAST, OP_NONE, S_BACK, OP_COL_INC, S_TRY, 1'b0};
            end
            S_PLACED: begin
                w = '{C_ROW_LAST, OP_ROW_FIRST, S_EMIT,
                      C_NEVER, OP_NONE, S_IDLE, OP_ROW_NEXT, S_TRY, 1'b0};
            end
            S_BACK: begin
                w = '{C_ROW_FIRST, OP_NONE, S_FAIL,
                      C_NEVER, OP_NONE, S_IDLE, OP_POP, S_RESUME, 1'b0};
            end
            S_RESUME: begin
                w = '{C_COL_OVER, OP_NONE, S_BACK,
                      C_NEVER, OP_NONE, S_IDLE, OP_NONE, S_TRY, 1'b0};
            end
            S_EMIT: begin
                w = '{C_OUT_BLOCKED, OP_NONE, S_EMIT,
                      C_ROW_LAST, OP_EMIT, S_IDLE, OP_EMIT, S_EMIT, 1'b0};
            end
            S_FAIL: begin
                w = '{C_OUT_BLOCKED, OP_NONE, S_FAIL,
                      C_NEVER, OP_NONE, S_IDLE, OP_EMIT_NONE, S_IDLE, 1'b0};
            end
            default: begin
                w = '{C_NEVER, OP_NONE, S_IDLE,
                      C_NEVER, OP_NONE, S_IDLE, OP_NONE, S_IDLE, 1'b0};
            end
        endcase
        return w;
    endfunction

    function automatic logic cond_eval(input t_cond cond, input t_flags f);
        logic v;
        case (cond)
            C_NEVER:       v = 1'b0;
            C_ALWAYS:      v = 1'b1;
            C_IN_VALID:    v = f.in_valid;
            C_SIZE_OK:     v = f.size_ok;
            C_FREE:        v = f.free;
            C_COL_LAST:    v = f.col_last;
            C_ROW_LAST:    v = f.row_last;
            C_ROW_FIRST:   v = f.row_first;
            C_COL_OVER:    v = f.col_over;
            C_OUT_BLOCKED: v = f.out_blocked;
            default:       v = 1'b0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* src/n_queens_first_solution.sv */
// Top level of the N-queens first-solution search: datapath with occupancy
// masks, placement registers and output register, driven by nqfs_seq.
// Depends on nqfs_pkg and nqfs_seq.
//
// One request carries a board size; the block searches depth first for the
// lexicographically smallest placement and returns one item per row, the last
// one flagged, or a single item with found low when no placement exists
// (sizes 0, 2, 3 and sizes above MAX_BOARD). Requests are served one at a
// time. A request is loaded and its size checked before the search starts;
// it then tests one column per step, moves to the next row in a further step
// after each queen placed, backtracks through a pop step and a resume step,
// and sends one result item per cycle while the output side is ready. The
// search time is set by the sequencer loop testing one column at a time; the
// output register lets the last result wait while the next request is taken.
`timescale 1ns / 1ps
`default_nettype none

module n_queens_first_solution #(
    parameter int MAX_BOARD = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [4:0] i_board_size,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [4:0]      o_queen_column,
    output logic [4:0]      o_row_index,
    output logic            o_found,
    output logic            o_last
);

    localparam int IDX_W   = $clog2(MAX_BOARD + 2);
    localparam int COL_N   = MAX_BOARD + 2;
    localparam int DIAG_N  = 2 * MAX_BOARD + 1;
    localparam int DIAG_W  = $clog2(DIAG_N);
    localparam int ADDR_W  = $clog2(MAX_BOARD);

    nqfs_pkg::t_op    op;
    nqfs_pkg::t_flags flags;

    logic [IDX_W-1:0]  r_n;
    logic              r_size_ok;
    logic [IDX_W-1:0]  r_row;
    logic [IDX_W-1:0]  r_col;
    logic [COL_N-1:0]  r_col_taken;
    logic [DIAG_N-1:0] r_sum_taken;
    logic [DIAG_N-1:0] r_dif_taken;
    logic [IDX_W-1:0]  r_placed [MAX_BOARD];

    logic              r_out_valid;
    logic [nqfs_pkg::FIELD_W-1:0] r_queen_column;
    logic [nqfs_pkg::FIELD_W-1:0] r_row_index;
    logic              r_found;
    logic              r_last;

    logic [ADDR_W-1:0] rd_addr;
    logic [IDX_W-1:0]  rd_col;
    logic [IDX_W-1:0]  mk_row;
    logic [IDX_W-1:0]  mk_col;
    logic [DIAG_W-1:0] sum_pos;
    logic [DIAG_W-1:0] dif_pos;
    logic [DIAG_W-1:0] free_sum;
    logic [DIAG_W-1:0] free_dif;
    logic              in_accept;

    nqfs_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_flags    (flags),
        .o_op       (op),
        .o_in_ready (o_in_ready)
    );

    assign in_accept = i_in_valid && o_in_ready;

    always_comb begin
        if (op == nqfs_pkg::OP_POP) begin
            rd_addr = ADDR_W'(r_row - IDX_W'(2));
            mk_row  = r_row - IDX_W'(1);
        end else begin
            rd_addr = ADDR_W'(r_row - IDX_W'(1));
            mk_row  = r_row;
        end
        rd_col  = r_placed[rd_addr];
        mk_col  = (op == nqfs_pkg::OP_POP) ? rd_col : r_col;
        sum_pos = DIAG_W'(mk_row) + DIAG_W'(mk_col);
        dif_pos = DIAG_W'(mk_row) + DIAG_W'(r_n) - DIAG_W'(mk_col);

        free_sum = DIAG_W'(r_row) + DIAG_W'(r_col);
        free_dif = DIAG_W'(r_row) + DIAG_W'(r_n) - DIAG_W'(r_col);

        flags.in_valid    = i_in_valid;
        flags.size_ok     = r_size_ok;
        flags.free        = !r_col_taken[r_col] && !r_sum_taken[free_sum]
                            && !r_dif_taken[free_dif];
        flags.col_last    = (r_col == r_n);
        flags.row_last    = (r_row == r_n);
        flags.row_first   = (r_row == IDX_W'(1));
        flags.col_over    = (r_col > r_n);
        flags.out_blocked = r_out_valid && !i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        case (op)
            nqfs_pkg::OP_LOAD: begin
                r_n         <= IDX_W'(i_board_size);
                r_size_ok   <= (i_board_size != '0)
                               && (32'(i_board_size) <= 32'(MAX_BOARD));
                r_row       <= IDX_W'(1);
                r_col       <= IDX_W'(1);
                r_col_taken <= '0;
                r_sum_taken <= '0;
                r_dif_taken <= '0;
            end
            nqfs_pkg::OP_PLACE: begin
                r_placed[rd_addr]    <= r_col;
                r_col_taken[mk_col]  <= 1'b1;
                r_sum_taken[sum_pos] <= 1'b1;
                r_dif_taken[dif_pos] <= 1'b1;
            end
            nqfs_pkg::OP_COL_INC: begin
                r_col <= r_col + IDX_W'(1);
            end
            nqfs_pkg::OP_ROW_NEXT: begin
                r_row <= r_row + IDX_W'(1);
                r_col <= IDX_W'(1);
            end
            nqfs_pkg::OP_ROW_FIRST: begin
                r_row <= IDX_W'(1);
            end
            nqfs_pkg::OP_POP: begin
                r_row                <= mk_row;
                r_col                <= rd_col + IDX_W'(1);
                r_col_taken[mk_col]  <= 1'b0;
                r_sum_taken[sum_pos] <= 1'b0;
                r_dif_taken[dif_pos] <= 1'b0;
            end
            nqfs_pkg::OP_EMIT: begin
                r_row <= r_row + IDX_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (op == nqfs_pkg::OP_EMIT || op == nqfs_pkg::OP_EMIT_NONE) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (op == nqfs_pkg::OP_EMIT) begin
            r_queen_column <= nqfs_pkg::FIELD_W'(rd_col);
            r_row_index    <= nqfs_pkg::FIELD_W'(r_row);
            r_found        <= 1'b1;
            r_last         <= (r_row == r_n);
        end else if (op == nqfs_pkg::OP_EMIT_NONE) begin
            r_queen_column <= '0;
            r_row_index    <= '0;
            r_found        <= 1'b0;
            r_last         <= 1'b1;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_queen_column = r_queen_column;
    assign o_row_index    = r_row_index;
    assign o_found        = r_found;
    assign o_last         = r_last;

endmodule

`default_nettype wire

/* src/nqfs_seq.sv */
// Microprogram sequencer: step register, control word lookup and
// three-way conditional branch. Depends on nqfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nqfs_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire nqfs_pkg::t_flags i_flags,
    output nqfs_pkg::t_op        o_op,
    output logic                 o_in_ready
);

    nqfs_pkg::t_step  r_step;
    nqfs_pkg::t_step  n_step;
    nqfs_pkg::t_uword word;
    logic             take_a;
    logic             take_b;

    always_comb begin
        word   = nqfs_pkg::ucode(r_step);
        take_a = nqfs_pkg::cond_eval(word.cond_a, i_flags);
        take_b = nqfs_pkg::cond_eval(word.cond_b, i_flags);
        if (take_a) begin
            o_op   = word.op_a;
            n_step = word.tgt_a;
        end else if (take_b) begin
            o_op   = word.op_b;
            n_step = word.tgt_b;
        end else begin
            o_op   = word.op_c;
            n_step = word.tgt_c;
        end
        o_in_ready = word.in_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= nqfs_pkg::S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

`default_nettype wire
